FILE: rtl/core/lmsfl_pkg.sv
// Shared types and constants of the linked multi-stack free list.
package lmsfl_pkg;

  localparam int unsigned CMD_W   = 1;
  localparam int unsigned STK_W   = 3;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned STAT_W  = 2;

  localparam logic [CMD_W-1:0]  CMD_PUSH = 1'b0;
  localparam logic [CMD_W-1:0]  CMD_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic capture;  // accept beat: latch request, read head memory
    logic look;     // pick slot, check, read link and data memories
    logic commit;   // update stores, load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy; // result register full and not drained this cycle
  } dp_stat_t;

endpackage

FILE: rtl/core/lmsfl_chan_if.sv
// Request and result channel interfaces of the linked multi-stack free list.
interface lmsfl_req_if;
  import lmsfl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [STK_W-1:0]         stack_index;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output command, output stack_index, output push_value,
                  input ready);
  modport sink   (input valid, input command, input stack_index, input push_value,
                  output ready);
endinterface

interface lmsfl_rsp_if;
  import lmsfl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] popped_value;

  modport source (output valid, output status, output popped_value, input ready);
  modport sink   (input valid, input status, input popped_value, output ready);
endinterface

FILE: rtl/core/lmsfl_ctrl.sv
// Sequencer of the linked multi-stack free list: accept, look up, commit.
module lmsfl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lmsfl_pkg::dp_stat_t  stat,
  output lmsfl_pkg::ctrl_cmd_t cmd
);
  import lmsfl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // hold until the result register can take the beat
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: rtl/core/lmsfl_dp.sv
// Datapath of the linked multi-stack free list: stores, free list and result register.
module lmsfl_dp #(
  parameter int unsigned NUM_STACKS  = 8,
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lmsfl_pkg::ctrl_cmd_t                   cmd,
  output lmsfl_pkg::dp_stat_t                    stat,
  input  logic [lmsfl_pkg::CMD_W-1:0]            in_command,
  input  logic [lmsfl_pkg::STK_W-1:0]            in_stack_index,
  input  logic signed [lmsfl_pkg::WORD_W-1:0]    in_push_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [lmsfl_pkg::STAT_W-1:0]           out_status,
  output logic signed [lmsfl_pkg::WORD_W-1:0]    out_popped_value
);
  import lmsfl_pkg::*;

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned HW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [AW:0] LAST_SLOT = (AW+1)'(STORE_DEPTH - 1);
  localparam logic [STK_W+HW-1:0] NUM_STK_EXT = (STK_W+HW)'(NUM_STACKS);

  // link entry: valid flag and next slot
  typedef struct packed {
    logic          vld;
    logic [AW-1:0] idx;
  } link_t;

  // memories
  logic [WORD_W-1:0] data_mem [STORE_DEPTH];
  link_t             link_mem [STORE_DEPTH];
  logic [AW-1:0]     head_mem [NUM_STACKS];
  logic [NUM_STACKS-1:0] head_vld_r;

  // free list and fill count: slots at or above wm_r were never taken
  logic [AW-1:0] free_head_r;
  logic          free_vld_r;
  logic [AW:0]   wm_r;

  // request and lookup registers
  logic [CMD_W-1:0]  cmd_r;
  logic [STK_W-1:0]  stk_r;
  logic [WORD_W-1:0] val_r;
  logic [AW-1:0]     head_q;
  logic              hvld_q;
  logic [AW-1:0]     slot_r;
  logic              fail_r;
  link_t             link_q;
  logic [WORD_W-1:0] data_q;

  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [WORD_W-1:0]     out_popped_r;

  logic [STK_W+HW-1:0] in_stk_ext, stk_ext;
  logic [HW-1:0]       in_hidx, hidx;
  logic                stk_ok;
  logic [AW-1:0]       slot_sel;
  logic                fail_nxt;
  logic                fresh;
  link_t               next_lnk;

  assign in_stk_ext = (STK_W+HW)'(in_stack_index);
  assign stk_ext    = (STK_W+HW)'(stk_r);
  assign in_hidx    = in_stk_ext[HW-1:0];
  assign hidx       = stk_ext[HW-1:0];
  assign stk_ok     = stk_ext < NUM_STK_EXT;

  assign slot_sel = (cmd_r == CMD_POP) ? head_q : free_head_r;
  assign fail_nxt = (cmd_r == CMD_POP) ? (!stk_ok || !hvld_q) : (!stk_ok || !free_vld_r);

  // an untaken slot still links to its successor, the last one to null
  assign fresh        = {1'b0, slot_r} >= wm_r;
  assign next_lnk.vld = fresh ? ({1'b0, slot_r} != LAST_SLOT) : link_q.vld;
  assign next_lnk.idx = fresh ? AW'({1'b0, slot_r} + (AW+1)'(1)) : link_q.idx;

  assign stat.out_busy = out_valid_r && !out_ready;

  // request capture and head lookup
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_command;
      stk_r  <= in_stack_index;
      val_r  <= in_push_value;
      head_q <= head_mem[in_hidx];
      hvld_q <= head_vld_r[in_hidx];
    end
  end

  // slot choice and link/data lookup
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      slot_r <= slot_sel;
      fail_r <= fail_nxt;
      link_q <= link_mem[slot_sel];
      data_q <= data_mem[slot_sel];
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (cmd.commit && !fail_r) begin
      if (cmd_r == CMD_PUSH) begin
        data_mem[slot_r] <= val_r;
        link_mem[slot_r] <= '{vld: hvld_q, idx: head_q};
        head_mem[hidx]   <= slot_r;
      end else begin
        link_mem[slot_r] <= '{vld: free_vld_r, idx: free_head_r};
        head_mem[hidx]   <= next_lnk.idx;
      end
    end
  end

  // control state of the lists
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r  <= '0;
      free_head_r <= '0;
      free_vld_r  <= 1'b1;
      wm_r        <= '0;
    end else if (cmd.commit && !fail_r) begin
      if (cmd_r == CMD_PUSH) begin
        head_vld_r[hidx] <= 1'b1;
        free_head_r      <= next_lnk.idx;
        free_vld_r       <= next_lnk.vld;
        if (fresh) wm_r <= wm_r + (AW+1)'(1);
      end else begin
        head_vld_r[hidx] <= next_lnk.vld;
        free_head_r      <= slot_r;
        free_vld_r       <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (cmd.commit) out_valid_r <= 1'b1;
    else if (out_ready)  out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (fail_r) begin
        out_status_r <= (cmd_r == CMD_POP) ? ST_EMPTY : ST_FULL;
        out_popped_r <= '0;
      end else begin
        out_status_r <= ST_OK;
        out_popped_r <= (cmd_r == CMD_POP) ? data_q : '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;

endmodule

FILE: rtl/core/linked_multi_stack_free_list.sv
// Linked multi-stack free list: NUM_STACKS stacks share one store of STORE_DEPTH words,
// each stack a linked list through a link memory, unused slots on a free list.
// Every request beat (push or pop) gives one result beat. One request is in
// flight at a time. The accepting cycle reads the head memory, the lookup
// state does the dependent link and data memory reads, and the update state
// commits all updates and loads the result register. Each memory has one
// registered read port. The result beat is valid once the commit has loaded
// the result register. The next request is accepted in the cycle after the
// commit, so a new request is taken only after the previous one has committed.
// A waiting result does not block acceptance of the next request; it only
// stalls that request's commit. The link memory needs no initialization pass:
// a fill count marks slots never taken, so the block is ready right after reset.
module linked_multi_stack_free_list #(
  parameter int unsigned NUM_STACKS  = 8,
  parameter int unsigned STORE_DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  lmsfl_req_if.sink   in_req,
  lmsfl_rsp_if.source out_rsp
);
  import lmsfl_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  lmsfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  lmsfl_dp #(
    .NUM_STACKS  (NUM_STACKS),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (ctrl_cmd),
    .stat             (dp_stat),
    .in_command       (in_req.command),
    .in_stack_index   (in_req.stack_index),
    .in_push_value    (in_req.push_value),
    .out_valid        (out_rsp.valid),
    .out_ready        (out_rsp.ready),
    .out_status       (out_rsp.status),
    .out_popped_value (out_rsp.popped_value)
  );

  // one request at a time
  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request accepted while another is in flight");

  a_look_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> ctrl_cmd.look)
    else $error("lookup did not follow accepted beat");

  // never overwrite an undelivered result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.commit |-> (!out_rsp.valid || out_rsp.ready))
    else $error("result register overwritten");

  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.commit |=> out_rsp.valid)
    else $error("commit gave no result beat");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status != ST_OK) |-> (out_rsp.popped_value == '0))
    else $error("failed request returned a value");

endmodule
